// ----- hdl/foccr_pkg.sv -----
// ----------------------------------------------------------------------------
// foccr_pkg
// Shared types, constants and fixed-point helpers of the dq current regulator.
// ----------------------------------------------------------------------------
package foccr_pkg;

    // register indexes of the configuration port
    localparam logic [1:0] RegPropGain  = 2'd0;
    localparam logic [1:0] RegIntGain   = 2'd1;
    localparam logic [1:0] RegRefLimit  = 2'd2;
    localparam logic [1:0] RegIntegLim  = 2'd3;

    // cordic working width and fixed constants
    localparam int CordW = 26;
    localparam logic signed [CordW-1:0] CordGainX = 26'sd2547003;

    // clarke and inverse clarke constants
    localparam logic signed [17:0] KClarke   = 18'sd18919;
    localparam logic signed [17:0] KSqrt3    = 18'sd28378;
    localparam logic signed [17:0] KNegHalf  = -18'sd16384;

    // sine/cosine result handed from the cordic to the sequencer
    typedef struct packed {
        logic               done;
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } t_sc_res;

    // arctangent of 2^-i in 2^22 per quarter-turn scale
    function automatic logic signed [CordW-1:0] atan_entry(input logic [3:0] i);
        logic signed [CordW-1:0] v;
        case (i)
            4'd0:    v = 26'sd2097152;
            4'd1:    v = 26'sd1238021;
            4'd2:    v = 26'sd654136;
            4'd3:    v = 26'sd332050;
            4'd4:    v = 26'sd166669;
            4'd5:    v = 26'sd83416;
            4'd6:    v = 26'sd41718;
            4'd7:    v = 26'sd20860;
            4'd8:    v = 26'sd10430;
            4'd9:    v = 26'sd5215;
            4'd10:   v = 26'sd2608;
            4'd11:   v = 26'sd1304;
            4'd12:   v = 26'sd652;
            4'd13:   v = 26'sd326;
            4'd14:   v = 26'sd163;
            default: v = 26'sd81;
        endcase
        return v;
    endfunction

    // arithmetic right shift rounding half up
    function automatic logic signed [55:0] rnd_shift(input logic signed [55:0] v,
                                                      input int unsigned s);
        logic signed [55:0] b;
        b = 56'sd1 <<< (s - 1);
        return (v + b) >>> s;
    endfunction

    // saturate to 16 bits signed
    function automatic logic signed [15:0] sat16(input logic signed [55:0] v);
        logic signed [15:0] r;
        if (v > 56'sd32767)       r = 16'sh7FFF;
        else if (v < -56'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

// ----- hdl/foccr_sincos.sv -----
// ----------------------------------------------------------------------------
// foccr_sincos
// Iterative 16-step rotation cordic giving Q1.14 sine and cosine of the angle.
// ----------------------------------------------------------------------------
module foccr_sincos #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output foccr_pkg::t_sc_res o_res
);
    import foccr_pkg::*;

    localparam int Sh = 16 - SINE_TABLE_BITS;
    localparam logic [15:0] AngMask = 16'hFFFF << Sh;

    typedef enum logic [1:0] {SC_IDLE, SC_ROT, SC_FIN} t_sc_state;

    t_sc_state                 r_state;
    logic signed [CordW-1:0]   r_x, r_y, r_z;
    logic [3:0]                r_iter;
    logic                      r_neg;
    logic                      r_done;
    logic signed [15:0]        r_sin, r_cos;

    logic [15:0]               qa;
    logic signed [16:0]        a_raw, a_fold;
    logic                      fold;
    logic signed [CordW-1:0]   dx, dy, xr, yr;
    logic signed [15:0]        xc, yc;

    // quantize and fold the angle to +-90 degrees
    always_comb begin
        qa     = i_angle & AngMask;
        a_raw  = {qa[15], qa};
        fold   = 1'b0;
        a_fold = a_raw;
        if (a_raw > 17'sd16384) begin
            a_fold = a_raw - 17'sd32768;
            fold   = 1'b1;
        end else if (a_raw < -17'sd16384) begin
            a_fold = a_raw + 17'sd32768;
            fold   = 1'b1;
        end
    end

    // shift terms and final rounding with clamp
    always_comb begin
        dx = r_y >>> r_iter;
        dy = r_x >>> r_iter;
        xr = (r_x + 26'sd128) >>> 8;
        yr = (r_y + 26'sd128) >>> 8;
        if (xr > 26'sd16384)       xc = 16'sd16384;
        else if (xr < -26'sd16384) xc = -16'sd16384;
        else                       xc = xr[15:0];
        if (yr > 26'sd16384)       yc = 16'sd16384;
        else if (yr < -26'sd16384) yc = -16'sd16384;
        else                       yc = yr[15:0];
    end

    // sequencer and rotation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
            r_done  <= 1'b0;
            r_iter  <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                SC_IDLE: begin
                    if (i_start) begin
                        r_x     <= CordGainX;
                        r_y     <= '0;
                        r_z     <= CordW'(a_fold) <<< 8;
                        r_neg   <= fold;
                        r_iter  <= '0;
                        r_state <= SC_ROT;
                    end
                end
                SC_ROT: begin
                    if (!r_z[CordW-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atan_entry(r_iter);
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atan_entry(r_iter);
                    end
                    r_iter <= r_iter + 4'd1;
                    if (r_iter == 4'd15) r_state <= SC_FIN;
                end
                SC_FIN: begin
                    r_cos   <= r_neg ? -xc : xc;
                    r_sin   <= r_neg ? -yc : yc;
                    r_done  <= 1'b1;
                    r_state <= SC_IDLE;
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_res = '{done: r_done, sin_v: r_sin, cos_v: r_cos};

endmodule

// ----- hdl/foc_current_regulator_core.sv -----
// ----------------------------------------------------------------------------
// foc_current_regulator_core
// dq PI current regulator: Clarke, Park, two PI loops, inverse Park/Clarke.
// ----------------------------------------------------------------------------
// An accepted item first needs sine and cosine: the sequencer starts the
// iterative cordic, which runs 16 rotations and a final rounding and then
// hands the values to the sequencer. Then come 20 sequencer steps that share
// one 36x18 multiply-accumulate unit for all transforms and PI terms, and
// then the output register is loaded. The input side is not ready while an
// item is in work, so a new item is taken only once the previous result is
// in the output register. A finished result waits in the output register and
// the next item is taken meanwhile; only when that next result is ready while
// the previous one still waits does the sequencer stall.
module foc_current_regulator_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input items
    input  logic          s_tvalid,
    output logic          s_tready,
    // phase_a_current, phase_b_current, elec_angle, d_current_ref, q_current_ref
    input  logic [79:0]   s_tdata,
    // result items
    output logic          m_tvalid,
    input  logic          m_tready,
    // volt_a, volt_b, volt_c, volt_d, volt_q, meas_d_current, meas_q_current
    output logic [111:0]  m_tdata,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import foccr_pkg::*;

    localparam logic [4:0] LastStep = 5'd19;

    typedef enum logic [1:0] {S_IDLE, S_ANGLE, S_CALC, S_OUT} t_state;

    t_state               r_state;
    logic [4:0]           r_step;
    logic [15:0]          r_kp, r_ki;
    logic [14:0]          r_rlim, r_ilim;
    logic signed [15:0]   r_ia, r_ib, r_dref, r_qref;
    logic [15:0]          r_angle;
    logic signed [17:0]   r_beta, r_valpha, r_vbeta;
    logic signed [15:0]   r_md, r_mq, r_vd, r_vq, r_vb, r_vc;
    logic signed [33:0]   r_pd, r_pq;
    logic signed [15:0]   r_integ_d, r_integ_q;
    logic signed [55:0]   r_acc;
    logic                 r_start;
    logic                 r_m_valid;
    logic [111:0]         r_m_data;

    t_sc_res              sc;
    logic signed [35:0]   m_a;
    logic signed [17:0]   m_b;
    logic [1:0]           m_op;
    logic signed [53:0]   prod;
    logic signed [16:0]   err_d, err_q, rl;
    logic signed [27:0]   istep, isum, ilim;
    logic signed [15:0]   integ_new;
    logic                 in_acc, cfg_wr;

    localparam logic [1:0] OpKeep = 2'd0;
    localparam logic [1:0] OpLoad = 2'd1;
    localparam logic [1:0] OpAdd  = 2'd2;
    localparam logic [1:0] OpSub  = 2'd3;

    foccr_sincos #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_angle (r_angle),
        .o_res   (sc)
    );

    assign s_tready = (r_state == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign rl       = {2'b00, r_rlim};

    // reference clamp
    function automatic logic signed [15:0] ref_clamp(input logic signed [15:0] v,
                                                      input logic signed [16:0] lim);
        logic signed [16:0] w;
        w = {v[15], v};
        if (w > lim)       w = lim;
        else if (w < -lim) w = -lim;
        return w[15:0];
    endfunction

    // register readback
    always_comb begin
        case (paddr[3:2])
            RegPropGain: prdata = {16'd0, r_kp};
            RegIntGain:  prdata = {16'd0, r_ki};
            RegRefLimit: prdata = {17'd0, r_rlim};
            RegIntegLim: prdata = {17'd0, r_ilim};
            default:     prdata = '0;
        endcase
    end

    // operand selection of the shared multiplier
    always_comb begin
        err_d = {r_dref[15], r_dref} - {r_md[15], r_md};
        err_q = {r_qref[15], r_qref} - {r_mq[15], r_mq};
        m_a   = '0;
        m_b   = '0;
        m_op  = OpKeep;
        case (r_step)
            5'd0:  begin m_a = 36'(r_ia) + (36'(r_ib) <<< 1); m_b = KClarke; m_op = OpLoad; end
            5'd1:  begin m_a = 36'(r_ia);     m_b = 18'(sc.cos_v); m_op = OpLoad; end
            5'd2:  begin m_a = 36'(r_beta);   m_b = 18'(sc.sin_v); m_op = OpAdd;  end
            5'd3:  begin m_a = 36'(r_beta);   m_b = 18'(sc.cos_v); m_op = OpLoad; end
            5'd4:  begin m_a = 36'(r_ia);     m_b = 18'(sc.sin_v); m_op = OpSub;  end
            5'd5:  begin m_a = 36'(err_d);    m_b = {2'b00, r_kp};  m_op = OpLoad; end
            5'd6:  begin m_a = 36'(err_q);    m_b = {2'b00, r_kp};  m_op = OpLoad; end
            5'd7:  begin m_a = 36'(r_pd);     m_b = {2'b00, r_ki};  m_op = OpLoad; end
            5'd8:  begin m_a = 36'(r_pq);     m_b = {2'b00, r_ki};  m_op = OpLoad; end
            5'd11: begin m_a = 36'(r_vd);     m_b = 18'(sc.cos_v); m_op = OpLoad; end
            5'd12: begin m_a = 36'(r_vq);     m_b = 18'(sc.sin_v); m_op = OpSub;  end
            5'd13: begin m_a = 36'(r_vd);     m_b = 18'(sc.sin_v); m_op = OpLoad; end
            5'd14: begin m_a = 36'(r_vq);     m_b = 18'(sc.cos_v); m_op = OpAdd;  end
            5'd15: begin m_a = 36'(r_valpha); m_b = KNegHalf;       m_op = OpLoad; end
            5'd16: begin m_a = 36'(r_vbeta);  m_b = KSqrt3;         m_op = OpAdd;  end
            5'd17: begin m_a = 36'(r_valpha); m_b = KNegHalf;       m_op = OpLoad; end
            5'd18: begin m_a = 36'(r_vbeta);  m_b = KSqrt3;         m_op = OpSub;  end
            default: m_op = OpKeep;
        endcase
        prod = m_a * m_b;
    end

    // integrator step and clamp, shared by both axes
    always_comb begin
        istep = 28'(rnd_shift(r_acc, 22));
        ilim  = 28'({1'b0, r_ilim});
        isum  = istep + 28'((r_step == 5'd8) ? r_integ_d : r_integ_q);
        if (isum > ilim)       isum = ilim;
        else if (isum < -ilim) isum = -ilim;
        integ_new = isum[15:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 16'd4096;
            r_ki   <= 16'd655;
            r_rlim <= 15'd10240;
            r_ilim <= 15'd14746;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                RegPropGain: r_kp   <= pwdata[15:0];
                RegIntGain:  r_ki   <= pwdata[15:0];
                RegRefLimit: r_rlim <= pwdata[14:0];
                RegIntegLim: r_ilim <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_start   <= 1'b0;
            r_m_valid <= 1'b0;
            r_integ_d <= '0;
            r_integ_q <= '0;
        end else begin
            r_start <= 1'b0;
            // taken result leaves; in the output state a taken result is replaced
            if (r_m_valid && m_tready && (r_state != S_OUT)) r_m_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ia    <= s_tdata[15:0];
                        r_ib    <= s_tdata[31:16];
                        r_angle <= s_tdata[47:32];
                        r_dref  <= ref_clamp(s_tdata[63:48], rl);
                        r_qref  <= ref_clamp(s_tdata[79:64], rl);
                        r_start <= 1'b1;
                        r_state <= S_ANGLE;
                    end
                end
                S_ANGLE: begin
                    if (sc.done) begin
                        r_step  <= '0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    // multiply-accumulate
                    case (m_op)
                        OpLoad:  r_acc <= 56'(prod);
                        OpAdd:   r_acc <= r_acc + 56'(prod);
                        OpSub:   r_acc <= r_acc - 56'(prod);
                        default: r_acc <= r_acc;
                    endcase
                    // write-back of the previous step's result
                    case (r_step)
                        5'd1:  r_beta    <= 18'(rnd_shift(r_acc, 15));
                        5'd3:  r_md      <= sat16(rnd_shift(r_acc, 14));
                        5'd5:  r_mq      <= sat16(rnd_shift(r_acc, 14));
                        5'd6:  r_pd      <= 34'(r_acc);
                        5'd7:  r_pq      <= 34'(r_acc);
                        5'd8:  r_integ_d <= integ_new;
                        5'd9: begin
                            r_integ_q <= integ_new;
                            r_vd <= sat16(56'(r_integ_d) + rnd_shift(56'(r_pd), 6));
                        end
                        5'd10: r_vq      <= sat16(56'(r_integ_q) + rnd_shift(56'(r_pq), 6));
                        5'd13: r_valpha  <= 18'(rnd_shift(r_acc, 14));
                        5'd15: r_vbeta   <= 18'(rnd_shift(r_acc, 14));
                        5'd17: r_vb      <= sat16(rnd_shift(r_acc, 15));
                        5'd19: r_vc      <= sat16(rnd_shift(r_acc, 15));
                        default: ;
                    endcase
                    if (r_step == LastStep) r_state <= S_OUT;
                    else                    r_step  <= r_step + 5'd1;
                end
                S_OUT: begin
                    if (!r_m_valid || m_tready) begin
                        r_m_data  <= {r_mq, r_md, r_vq, r_vd, r_vc, r_vb,
                                      sat16(56'(r_valpha))};
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // an accepted item closes the input side on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !s_tready)
        else $error("input still ready after accepting an item");

    // the cordic only finishes while the sequencer waits for it
    a_done_in_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc.done |-> (r_state == S_ANGLE))
        else $error("sine/cosine finished outside the angle wait");

    // a pending result is never overwritten
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("pending result changed");

endmodule
